### hdl/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
// No dependencies; used by mexp_regs, mexp_modmul and modular_exponentiation.
`default_nettype none

package mexp_pkg;

    // operand width default, and fixed widths of the ports
    localparam int WIDTH_DEF = 32;
    localparam int FIELD_W   = 32;
    localparam int CFG_W     = 32;
    localparam int ADDR_W    = 3;

    // register indexes, taken from paddr[2]
    localparam logic [0:0] REG_MODULUS  = 1'b0;
    localparam logic [0:0] REG_EXPONENT = 1'b1;

    // key set handed from the register file to the datapath
    typedef struct packed {
        logic [CFG_W-1:0] modulus;
        logic [CFG_W-1:0] exponent;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/mexp_regs.sv
// Configuration register file (modulus, exponent) behind an APB-style port.
// Depends on mexp_pkg for widths, register indexes and cfg_t.
`default_nettype none

module mexp_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mexp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mexp_pkg::CFG_W-1:0]    pwdata,
    output logic      [mexp_pkg::CFG_W-1:0]    prdata,
    output logic                               pready,
    output mexp_pkg::cfg_t                     cfg
);

    logic [mexp_pkg::CFG_W-1:0] modulus_reg;
    logic [mexp_pkg::CFG_W-1:0] exponent_reg;
    logic                       wr_en;
    logic [0:0]                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= mexp_pkg::CFG_W'(1);
            exponent_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                mexp_pkg::REG_MODULUS:  modulus_reg  <= pwdata;
                mexp_pkg::REG_EXPONENT: exponent_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mexp_pkg::REG_MODULUS:  prdata = modulus_reg;
            mexp_pkg::REG_EXPONENT: prdata = exponent_reg;
            default:                prdata = '0;
        endcase
    end

    assign cfg.modulus  = modulus_reg;
    assign cfg.exponent = exponent_reg;

endmodule

`default_nettype wire

### hdl/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: product = a * b mod m,
// one bit of a per cycle, MSB first. Needs b <= m and m nonzero. Uses mexp_pkg.
`default_nettype none

module mexp_modmul #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic [WIDTH-1:0] m,
    output logic                  done,
    output logic      [WIDTH-1:0] product
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [WIDTH-1:0]   a_sr_reg,  a_sr_next;
    logic [WIDTH-1:0]   b_reg,     b_next;
    logic [WIDTH-1:0]   r_reg,     r_next;

    logic [WIDTH+1:0]   sum;
    logic [WIDTH+1:0]   m_ext;
    logic [WIDTH+1:0]   red1;
    logic [WIDTH+1:0]   red2;

    // 2r + bit*b stays below 3m, so two conditional subtracts bring it back under m
    always_comb
    begin
        m_ext = {2'b00, m};
        sum   = {1'b0, r_reg, 1'b0} + (a_sr_reg[WIDTH-1] ? {2'b00, b_reg} : '0);
        red1  = (sum  >= m_ext) ? sum  - m_ext : sum;
        red2  = (red1 >= m_ext) ? red1 - m_ext : red1;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_sr_next = a_sr_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            a_sr_next = a;
            b_next    = b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next    = red2[WIDTH-1:0];
            a_sr_next = {a_sr_reg[WIDTH-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sr_reg <= a_sr_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

`default_nettype wire

### hdl/modular_exponentiation.sv
// Right-to-left binary modular exponentiation: power_result = base_value ^ exponent mod
// modulus, one word at a time. The base is first reduced mod modulus on the shared
// bit-serial multiplier. Each exponent bit then costs a decision step, an optional
// multiply and a square on that same unit, except that the top bit gets no square.
// A multiplication is started, steps through every bit of its first operand and then
// signals done. A zero exponent (result 1) or, with a nonzero exponent, a zero modulus
// (result 0) skips the multiplier and goes straight to delivery. The next word can be
// taken as soon as the result is loaded, since the load returns the state to idle.
// The input is stalled while a word is in work; a finished result waits in the
// output register while the next word is taken. Depends on mexp_pkg, mexp_regs and
// mexp_modmul.
`default_nettype none

module modular_exponentiation #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mexp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mexp_pkg::CFG_W-1:0]    pwdata,
    output logic      [mexp_pkg::CFG_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mexp_pkg::FIELD_W-1:0]  base_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [mexp_pkg::FIELD_W-1:0]  power_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL,
        ST_SQR,
        ST_DELIVER
    } state_t;

    mexp_pkg::cfg_t cfg;

    state_t                        state_reg,     state_next;
    logic                          start_reg,     start_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mexp_pkg::FIELD_W-1:0]  power_reg,     power_next;
    logic [WIDTH-1:0]              base_reg,      base_next;
    logic [WIDTH-1:0]              acc_reg,       acc_next;
    logic [WIDTH-1:0]              exp_reg,       exp_next;
    logic [WIDTH-1:0]              mod_reg,       mod_next;

    logic             in_take;
    logic             out_free;
    logic             mul_done;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_p;
    logic             exp_more;

    mexp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mexp_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .m       (mod_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_take      = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign exp_more     = (exp_reg[WIDTH-1:1] != '0);
    assign out_valid    = out_valid_reg;
    assign power_result = power_reg;

    // operand routing for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_REDUCE:
            begin
                mul_a = base_reg;
                mul_b = WIDTH'(1);
            end
            ST_MUL:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        power_next     = power_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    base_next = base_value[WIDTH-1:0];
                    exp_next  = cfg.exponent[WIDTH-1:0];
                    mod_next  = cfg.modulus[WIDTH-1:0];
                    if (cfg.exponent[WIDTH-1:0] == '0)
                    begin
                        acc_next   = WIDTH'(1);
                        state_next = ST_DELIVER;
                    end
                    else if (cfg.modulus[WIDTH-1:0] == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_DELIVER;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    base_next  = mul_p;
                    acc_next   = WIDTH'(1);
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                // a clear low bit always has set bits above it here
                start_next = 1'b1;
                state_next = exp_reg[0] ? ST_MUL : ST_SQR;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    acc_next = mul_p;
                    if (exp_more)
                    begin
                        start_next = 1'b1;
                        state_next = ST_SQR;
                    end
                    else
                    begin
                        state_next = ST_DELIVER;
                    end
                end
            end
            ST_SQR:
            begin
                if (mul_done)
                begin
                    base_next  = mul_p;
                    exp_next   = {1'b0, exp_reg[WIDTH-1:1]};
                    state_next = ST_STEP;
                end
            end
            ST_DELIVER:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    power_next              = '0;
                    power_next[WIDTH-1:0]   = acc_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        power_reg <= power_next;
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        exp_reg   <= exp_next;
        mod_reg   <= mod_next;
    end

    // multiplier results only arrive while a multiplication is owned
    a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR))
        else $error("multiplier done outside a multiply state");

    // a new result word is loaded only from the delivery state
    a_out_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DELIVER)
        else $error("output loaded outside delivery");

    // the exponent scan never runs out of bits mid-word
    a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP || state_reg == ST_MUL || state_reg == ST_SQR)
            |-> (exp_reg != '0 && mod_reg != '0))
        else $error("exponent or modulus zero during scan");

    // an accepted word always leaves idle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg != ST_IDLE)
        else $error("accepted word did not start");

endmodule

`default_nettype wire
